>>> rtl/pesp_pkg.sv
package pesp_pkg;

    localparam int SLOTS_DEF = 64;
    localparam logic [17:0] AGE_MAX = 18'h3FFFF;
    localparam logic [2:0] PRIO_MAX = 3'd4;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_SPAWN  = 3'd1,
        CMD_REM_ID = 3'd2,
        CMD_REM_AGE = 3'd3,
        CMD_REM_ALL = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  delta;
        logic [2:0]  priority_req;
        logic [15:0] lifetime;
        logic [15:0] fade_out;
        logic [31:0] target_id;
        logic [17:0] age_limit;
    } in_item_t;

    typedef struct packed {
        logic [31:0] new_id;
        logic [6:0]  removed_count;
        logic [6:0]  active_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_step;
        logic commit;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } ctl_stat_t;

endpackage

>>> rtl/pesp_ctrl.sv
module pesp_ctrl
    import pesp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_free,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl,
    output logic      busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_SCAN;
            ST_SCAN:  if (stat.scan_last) state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.start = in_fire;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_SCAN:  ctl.scan_step = 1'b1;
            ST_WRITE: ctl.commit = 1'b1;
            ST_DONE:  ctl.finish = out_free;
            default:  ;
        endcase
    end

endmodule

>>> rtl/pesp_dp.sv
module pesp_dp
    import pesp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctl_cmd_t  ctl,
    input  in_item_t  item,
    input  logic      enable,
    output ctl_stat_t stat,
    output out_item_t result,
    output logic      result_load
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] used_reg;
    logic [31:0] id_mem [SLOTS];
    logic [2:0]  pr_mem [SLOTS];
    logic [17:0] age_mem [SLOTS];
    logic [15:0] life_mem [SLOTS];
    logic [15:0] fade_mem [SLOTS];

    in_item_t    item_reg;
    logic [31:0] next_id_reg;
    logic [IW-1:0] idx_reg;
    logic          rd_v_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0] rd_id_reg;
    logic [2:0]  rd_pr_reg;
    logic [17:0] rd_age_reg;
    logic [15:0] rd_life_reg;
    logic [15:0] rd_fade_reg;
    logic [CW-1:0] removed_reg;
    logic [CW-1:0] active_reg;
    logic          free_found_reg;
    logic [IW-1:0] pick_reg;
    logic          best_v_reg;
    logic [2:0]  best_pr_reg;
    logic [17:0] best_age_reg;
    logic [31:0] best_id_reg;
    logic          id_hit_reg;
    logic [IW-1:0] age_wr_idx_reg;
    logic [17:0]   age_wr_val_reg;
    logic          age_wr_reg;

    logic [18:0] age_sum;
    logic [17:0] age_new;
    logic [15:0] f_eff;
    logic [17:0] life_ext;
    logic        expire;
    logic        better;
    logic        clr_hit;
    logic        rd_used;

    assign stat.scan_last = (idx_reg == IW'(SLOTS - 1));
    assign rd_used = used_reg[rd_idx_reg];

    assign age_sum  = {1'b0, rd_age_reg} + 19'(item_reg.delta);
    assign age_new  = age_sum[18] ? AGE_MAX : age_sum[17:0];
    assign f_eff    = (rd_fade_reg == 16'd0) ? 16'd1 : rd_fade_reg;
    assign life_ext = 18'(rd_life_reg);
    assign expire   = (age_new >= life_ext) && ((age_new - life_ext) >= 18'(f_eff));
    assign better   = !best_v_reg || (rd_pr_reg < best_pr_reg) ||
                      (rd_pr_reg == best_pr_reg && (rd_age_reg > best_age_reg ||
                      (rd_age_reg == best_age_reg && rd_id_reg < best_id_reg)));

    always_comb
    begin
        clr_hit = 1'b0;
        if (rd_v_reg && rd_used)
        begin
            case (item_reg.cmd)
                CMD_TICK:    clr_hit = enable && rd_life_reg != 16'd0 && expire;
                CMD_REM_ID:  clr_hit = !id_hit_reg && item_reg.target_id != 32'd0
                                       && rd_id_reg == item_reg.target_id;
                CMD_REM_AGE: clr_hit = rd_age_reg >= item_reg.age_limit;
                CMD_REM_ALL: clr_hit = 1'b1;
                default:     clr_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_id_reg   <= id_mem[idx_reg];
        rd_pr_reg   <= pr_mem[idx_reg];
        rd_age_reg  <= age_mem[idx_reg];
        rd_life_reg <= life_mem[idx_reg];
        rd_fade_reg <= fade_mem[idx_reg];
        rd_idx_reg  <= idx_reg;
        if (age_wr_reg)
        begin
            age_mem[age_wr_idx_reg] <= age_wr_val_reg;
        end
        else if (ctl.commit && item_reg.cmd == CMD_SPAWN)
        begin
            age_mem[pick_reg] <= '0;
        end
        if (ctl.commit && item_reg.cmd == CMD_SPAWN)
        begin
            id_mem[pick_reg]   <= next_id_reg;
            pr_mem[pick_reg]   <= (item_reg.priority_req > PRIO_MAX) ? PRIO_MAX
                                  : item_reg.priority_req;
            life_mem[pick_reg] <= item_reg.lifetime;
            fade_mem[pick_reg] <= item_reg.fade_out;
        end
        age_wr_idx_reg <= rd_idx_reg;
        age_wr_val_reg <= age_new;
        if (ctl.start)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            next_id_reg    <= 32'd1;
            idx_reg        <= '0;
            rd_v_reg       <= 1'b0;
            removed_reg    <= '0;
            active_reg     <= '0;
            free_found_reg <= 1'b0;
            pick_reg       <= '0;
            best_v_reg     <= 1'b0;
            best_pr_reg    <= '0;
            best_age_reg   <= '0;
            best_id_reg    <= '0;
            id_hit_reg     <= 1'b0;
            age_wr_reg     <= 1'b0;
            result_load    <= 1'b0;
            result         <= '0;
        end
        else
        begin
            result_load <= 1'b0;
            rd_v_reg    <= ctl.scan_step;
            age_wr_reg  <= rd_v_reg && rd_used && item_reg.cmd == CMD_TICK && enable
                           && rd_life_reg != 16'd0;
            if (ctl.start)
            begin
                idx_reg        <= '0;
                removed_reg    <= '0;
                free_found_reg <= 1'b0;
                best_v_reg     <= 1'b0;
                id_hit_reg     <= 1'b0;
            end
            else if (ctl.scan_step && !stat.scan_last)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (rd_v_reg)
            begin
                if (clr_hit)
                begin
                    used_reg[rd_idx_reg] <= 1'b0;
                    removed_reg <= removed_reg + CW'(1);
                    active_reg  <= active_reg - CW'(1);
                    if (item_reg.cmd == CMD_REM_ID)
                    begin
                        id_hit_reg <= 1'b1;
                    end
                end
                if (item_reg.cmd == CMD_SPAWN)
                begin
                    if (!rd_used && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        pick_reg       <= rd_idx_reg;
                    end
                    else if (rd_used && !free_found_reg && better)
                    begin
                        best_v_reg   <= 1'b1;
                        best_pr_reg  <= rd_pr_reg;
                        best_age_reg <= rd_age_reg;
                        best_id_reg  <= rd_id_reg;
                        pick_reg     <= rd_idx_reg;
                    end
                end
            end
            if (ctl.commit)
            begin
                result.new_id <= '0;
                if (item_reg.cmd == CMD_SPAWN)
                begin
                    used_reg[pick_reg] <= 1'b1;
                    result.new_id <= next_id_reg;
                    next_id_reg   <= (next_id_reg == 32'hFFFF_FFFF) ? 32'd1
                                     : next_id_reg + 32'd1;
                    removed_reg   <= free_found_reg ? CW'(0) : CW'(1);
                    if (free_found_reg)
                    begin
                        active_reg <= active_reg + CW'(1);
                    end
                end
            end
            if (ctl.finish)
            begin
                result_load <= 1'b1;
            end
            result.removed_count <= (CW > 7 && removed_reg > CW'(127)) ? 7'd127
                                    : 7'(removed_reg);
            result.active_count  <= (CW > 7 && active_reg > CW'(127)) ? 7'd127
                                    : 7'(active_reg);
        end
    end

endmodule

>>> rtl/priority_evicting_slot_pool_top.sv
// channel | direction | signals
// in      | input     | in_valid, in_ready, in_data (in_item_t)
// out     | output    | out_valid, out_ready, out_data (out_item_t)
// cfg     | input     | cfg_valid, cfg_ready, cfg_data (enable)
// Each transaction, from acceptance to the next acceptance, steps through the slot
// memory slot by slot, then through a read wait, the commit and the result load,
// and returns to idle; the result becomes valid once it has been loaded.
// Reset clears the pool, sets the next id to one and enable to one.
// A waiting result holds the following transaction in its last state until it leaves.
module priority_evicting_slot_pool_top
    import pesp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;
    logic      busy;
    logic      enable_reg;
    logic      out_valid_reg;
    logic      result_load;
    out_item_t result;

    assign in_ready  = !busy;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                enable_reg <= cfg_data;
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            out_data <= result;
        end
    end

    pesp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_valid && in_ready),
        .out_free (!out_valid_reg || out_ready),
        .stat     (stat),
        .ctl      (ctl),
        .busy     (busy)
    );

    pesp_dp #(.SLOTS(SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .item        (in_data),
        .enable      (enable_reg),
        .stat        (stat),
        .result      (result),
        .result_load (result_load)
    );

endmodule
